// ===== src/apq_pkg.sv =====
// Package for the adaptive palette quantizer: item types, memory request types,
// the controller state type, register indexes and the channel expansion table.
// It depends on nothing.
package apq_pkg;

    // Palette and color geometry.
    localparam int PAL_MAX    = 16;
    localparam int PAL_IDX_W  = 4;
    localparam int CH_W       = 5;
    localparam int KEY_W      = 3 * CH_W;
    localparam int MAP_ADDR_W = KEY_W;
    localparam int DIST_W     = 8;
    localparam int PRESET_REGS = 4;
    localparam int LANE_W     = 16;

    localparam logic [DIST_W-1:0] DIST_SAT = 8'd255;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int THR_W      = 10;
    localparam int PCNT_W     = 5;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = 10'd10;
    localparam logic [PCNT_W-1:0] PCNT_RST      = 5'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_PRESET_CNT  = 3'd1,
        CFG_TRANSPARENT = 3'd2,
        CFG_PRESET_A    = 3'd3,
        CFG_PRESET_B    = 3'd4,
        CFG_PRESET_C    = 3'd5,
        CFG_PRESET_D    = 3'd6
    } t_cfg_reg;

    // Items on the two channels.
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [PAL_IDX_W-1:0] palette_index;
        logic                 entry_added;
        logic [KEY_W-1:0]     added_color;
        logic                 merged_close;
        logic                 palette_overflow;
    } t_out_item;

    // One entry of the color map memory.
    typedef struct packed {
        logic                 vld;
        logic [PAL_IDX_W-1:0] idx;
    } t_map_entry;

    // Access to the color map memory.
    typedef struct packed {
        logic                  rd_en;
        logic [MAP_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [MAP_ADDR_W-1:0] wr_addr;
        t_map_entry            wr_data;
    } t_map_req;

    // Access to the palette entry memory.
    typedef struct packed {
        logic                 rd_en;
        logic [PAL_IDX_W-1:0] rd_addr;
        logic                 wr_en;
        logic [PAL_IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0]     wr_data;
    } t_pal_req;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // Expansion of a 5-bit channel to 8 bits, c * 255 / 31 rounded down.
    localparam logic [7:0] EXPAND_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    function automatic logic [7:0] expand5(input logic [CH_W-1:0] c);
        return EXPAND_LUT[c];
    endfunction

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Saturated Manhattan distance between two RGB555 colors.
    function automatic logic [DIST_W-1:0] color_dist(input logic [KEY_W-1:0] x,
                                                     input logic [KEY_W-1:0] y);
        logic [9:0] sum;
        sum = 10'(absdiff8(expand5(x[4:0]),   expand5(y[4:0])))
            + 10'(absdiff8(expand5(x[9:5]),   expand5(y[9:5])))
            + 10'(absdiff8(expand5(x[14:10]), expand5(y[14:10])));
        return (sum > 10'(DIST_SAT)) ? DIST_SAT : sum[DIST_W-1:0];
    endfunction

endpackage

// ===== src/apq_map_mem.sv =====
// Color map memory: one valid bit and a palette index per RGB555 color.
// Synchronous, one write and one registered read per cycle. Uses apq_pkg.
module apq_map_mem (
    input  logic                  i_clk,
    input  apq_pkg::t_map_req     i_req,
    output apq_pkg::t_map_entry   o_rd_data
);
    import apq_pkg::*;

    localparam int DEPTH = 1 << MAP_ADDR_W;

    t_map_entry mem [DEPTH];
    t_map_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/apq_palette.sv =====
// Palette entry memory with a registered read port, followed by the distance
// unit that compares the entry just read with the current color. Uses apq_pkg.
module apq_palette #(
    parameter int PALETTE_SIZE = apq_pkg::PAL_MAX
) (
    input  logic                        i_clk,
    input  apq_pkg::t_pal_req           i_req,
    input  logic [apq_pkg::KEY_W-1:0]   i_key,
    output logic [apq_pkg::DIST_W-1:0]  o_dist
);
    import apq_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_SIZE);

    logic [KEY_W-1:0] mem [PALETTE_SIZE];
    logic [KEY_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr[IDX_W-1:0]] <= i_req.wr_data;
        end
    end

    // Read port.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr[IDX_W-1:0]];
        end
    end

    // Distance of the entry read in the previous cycle.
    assign o_dist = color_dist(i_key, r_rd_data);

endmodule

// ===== src/adaptive_palette_quantizer_core.sv =====
// Adaptive palette quantizer: maps RGB888 pixels to 4-bit palette indexes.
// A preset or already seen color moves to the output register in the lookup state once
// that is free; an unseen color searches the N adaptive entries, one palette read per
// cycle, then passes the decide and output states. A new item is taken only in the idle
// state, after the last one is in the output register. After reset a clearing pass writes
// all 32768 color map entries, one per cycle; no item is accepted until it ends.
module adaptive_palette_quantizer_core #(
    parameter int PALETTE_SIZE = apq_pkg::PAL_MAX
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  apq_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output apq_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [apq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [apq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import apq_pkg::*;

    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);

    // Configuration registers.
    logic [THR_W-1:0]      r_threshold;
    logic [PCNT_W-1:0]     r_preset_count;
    logic [KEY_W-1:0]      r_transparent;
    logic [CFG_DATA_W-1:0] r_preset [PRESET_REGS];

    // Control and datapath registers.
    t_state                r_state, n_state;
    logic [MAP_ADDR_W-1:0] r_clr_addr;
    logic [KEY_W-1:0]      r_key;
    logic [CNT_W-1:0]      r_added_count;
    logic [CNT_W-1:0]      r_issue_cnt;
    logic [CNT_W-1:0]      r_scan_n;
    logic                  r_cmp_vld;
    logic [PAL_IDX_W-1:0]  r_cmp_slot;
    logic [DIST_W-1:0]     r_best_d;
    logic [PAL_IDX_W-1:0]  r_best_s;
    t_out_item             r_res;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    // Combinational signals.
    logic                  w_accept;
    logic                  w_out_free;
    logic [KEY_W-1:0]      w_in_key;
    logic [CNT_W-1:0]      w_start;
    logic [CNT_W:0]        w_total;
    logic [CNT_W-1:0]      w_avail;
    logic [CNT_W-1:0]      w_scan_n;
    logic                  w_pre_hit;
    logic [PAL_IDX_W-1:0]  w_pre_idx;
    logic                  w_lk_done;
    logic [PAL_IDX_W-1:0]  w_lk_idx;
    t_out_item             w_lk_res;
    t_out_item             w_dec_res;
    logic [CNT_W:0]        w_slot;
    logic [DIST_W-1:0]     w_dist;
    t_map_entry            w_map_rd;
    t_map_req              w_map_req;
    t_pal_req              w_pal_req;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Each channel reduces to 5 bits as c * 31 / 248, which is c / 8.
    assign w_in_key = {i_in_item.blue_in[7:3], i_in_item.green_in[7:3], i_in_item.red_in[7:3]};

    // Reserved slots, limited to the palette size.
    assign w_start = (r_preset_count > PCNT_W'(PALETTE_SIZE)) ?
                     CNT_W'(PALETTE_SIZE) : r_preset_count[CNT_W-1:0];
    assign w_total = {1'b0, w_start} + {1'b0, r_added_count};
    assign w_avail = CNT_W'(PALETTE_SIZE) - w_start;
    assign w_scan_n = (r_added_count < w_avail) ? r_added_count : w_avail;
    assign w_slot  = {1'b0, w_start} + {1'b0, r_issue_cnt};

    // Preset match: the highest matching preset slot, else the transparent color.
    always_comb begin
        w_pre_hit = 1'b0;
        w_pre_idx = '0;
        for (int s = 1; s < PAL_MAX; s++) begin
            if (s < int'(w_start) &&
                r_preset[2'(s >> 2)][(s & 3) * LANE_W +: KEY_W] == r_key) begin
                w_pre_hit = 1'b1;
                w_pre_idx = PAL_IDX_W'(s);
            end
        end
        if (w_start != '0 && !w_pre_hit && r_key == r_transparent) begin
            w_pre_hit = 1'b1;
            w_pre_idx = '0;
        end
    end

    // Lookup result for a preset or previously seen color.
    assign w_lk_done = w_pre_hit || w_map_rd.vld;
    assign w_lk_idx  = w_pre_hit ? w_pre_idx : w_map_rd.idx;

    always_comb begin
        w_lk_res               = '0;
        w_lk_res.palette_index = w_lk_idx;
    end

    // Decision for an unseen color once the search is over.
    always_comb begin
        w_dec_res = '0;
        priority if ({2'b00, r_best_d} < r_threshold && w_total != '0) begin
            w_dec_res.palette_index = r_best_s;
            w_dec_res.merged_close  = 1'b1;
        end else if (w_total >= (CNT_W + 1)'(PALETTE_SIZE)) begin
            w_dec_res.palette_index    = r_best_s;
            w_dec_res.palette_overflow = 1'b1;
        end else begin
            w_dec_res.palette_index = PAL_IDX_W'(w_total);
            w_dec_res.entry_added   = 1'b1;
            w_dec_res.added_color   = r_key;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                priority if (w_lk_done) begin
                    if (w_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (w_scan_n == '0) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_issue_cnt == r_scan_n && !r_cmp_vld) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Memory requests and the input stall.
    always_comb begin
        o_in_stall = 1'b1;
        w_map_req  = '0;
        w_pal_req  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_map_req.wr_en   = 1'b1;
                w_map_req.wr_addr = r_clr_addr;
            end
            ST_IDLE: begin
                o_in_stall        = 1'b0;
                w_map_req.rd_en   = i_in_valid;
                w_map_req.rd_addr = w_in_key;
            end
            ST_SCAN: begin
                w_pal_req.rd_en   = (r_issue_cnt < r_scan_n);
                w_pal_req.rd_addr = PAL_IDX_W'(w_slot);
            end
            ST_DECIDE: begin
                w_map_req.wr_en       = 1'b1;
                w_map_req.wr_addr     = r_key;
                w_map_req.wr_data.vld = 1'b1;
                w_map_req.wr_data.idx = w_dec_res.palette_index;
                w_pal_req.wr_en       = w_dec_res.entry_added;
                w_pal_req.wr_addr     = w_dec_res.palette_index;
                w_pal_req.wr_data     = r_key;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // State register and clearing pass address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Configuration writes, taken in any state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RST;
            r_preset_count <= PCNT_RST;
            r_transparent  <= '0;
            for (int i = 0; i < PRESET_REGS; i++) begin
                r_preset[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:   r_threshold    <= i_cfg_data[THR_W-1:0];
                CFG_PRESET_CNT:  r_preset_count <= i_cfg_data[PCNT_W-1:0];
                CFG_TRANSPARENT: r_transparent  <= i_cfg_data[KEY_W-1:0];
                CFG_PRESET_A:    r_preset[0]    <= i_cfg_data;
                CFG_PRESET_B:    r_preset[1]    <= i_cfg_data;
                CFG_PRESET_C:    r_preset[2]    <= i_cfg_data;
                CFG_PRESET_D:    r_preset[3]    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Count of adaptively added entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_added_count <= '0;
        end else if (r_state == ST_DECIDE && w_dec_res.entry_added) begin
            r_added_count <= r_added_count + 1'b1;
        end
    end

    // Item key, captured at acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= w_in_key;
        end
    end

    // Nearest entry search: one read issued and one distance compared per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld   <= 1'b0;
            r_issue_cnt <= '0;
        end else if (r_state == ST_LOOKUP) begin
            r_cmp_vld   <= 1'b0;
            r_issue_cnt <= '0;
            r_scan_n    <= w_scan_n;
            r_best_d    <= DIST_SAT;
            r_best_s    <= '0;
        end else if (r_state == ST_SCAN) begin
            r_cmp_vld <= w_pal_req.rd_en;
            if (w_pal_req.rd_en) begin
                r_issue_cnt <= r_issue_cnt + 1'b1;
                r_cmp_slot  <= PAL_IDX_W'(w_slot);
            end
            // Strict compare keeps the lowest slot on ties.
            if (r_cmp_vld && w_dist < r_best_d) begin
                r_best_d <= w_dist;
                r_best_s <= r_cmp_slot;
            end
        end
    end

    // Result of an unseen color, held until the output register is free.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE) begin
            r_res <= w_dec_res;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_LOOKUP && w_lk_done && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out_item  <= w_lk_res;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out_item  <= r_res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Color map memory.
    apq_map_mem u_map_mem (
        .i_clk     (i_clk),
        .i_req     (w_map_req),
        .o_rd_data (w_map_rd)
    );

    // Palette entries and distance unit.
    apq_palette #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_palette (
        .i_clk  (i_clk),
        .i_req  (w_pal_req),
        .i_key  (r_key),
        .o_dist (w_dist)
    );

endmodule

// ===== tb/apq_checker.sv =====
// Checker for the adaptive palette quantizer: watches the pixel, result and register
// ports, predicts every result and compares it field by field with what comes out.
// Depends on apq_pkg for the item types and the register indexes.
`timescale 1ns / 100ps

module apq_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  apq_pkg::t_in_item               i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  apq_pkg::t_out_item              i_out_item,
    input  logic                            i_cfg_we,
    input  logic [apq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [apq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_added_count,
    output int                              o_adds,
    output int                              o_merges,
    output int                              o_overflows
);
    import apq_pkg::*;

    // Shadow copy of the registers.
    logic [9:0]  thr_q;
    logic [4:0]  pcnt_q;
    logic [14:0] transp_q;
    logic [63:0] preset_q [4];

    // Shadow copy of the color map, the palette and the adaptive entry count.
    bit          map_vld  [32768];
    logic [3:0]  map_slot [32768];
    logic [14:0] pal_q    [16];
    int          n_added;

    t_out_item   index_q [$];
    t_out_item   want;

    // An 8-bit channel reduced to 5 bits.
    function automatic logic [4:0] to_five(input logic [7:0] v);
        return 5'((32'(v) * 31) / 248);
    endfunction

    // A 5-bit channel widened back to the 0..255 scale.
    function automatic int to_eight(input logic [4:0] c);
        return (int'(c) * 255) / 31;
    endfunction

    // Manhattan distance of two RGB555 colors, saturated at 255.
    function automatic int key_distance(input logic [14:0] x, input logic [14:0] y);
        int sum;
        int a;
        int b;
        sum = 0;
        for (int ch = 0; ch < 3; ch++) begin
            a = to_eight(x[5*ch +: 5]);
            b = to_eight(y[5*ch +: 5]);
            sum += (a > b) ? a - b : b - a;
        end
        return (sum > 255) ? 255 : sum;
    endfunction

    function automatic logic [14:0] preset_color(input int slot);
        return preset_q[slot / 4][16 * (slot % 4) +: 15];
    endfunction

    // Works out the palette index of one pixel and updates the shadow state.
    function automatic t_out_item quantize_pixel(input t_in_item px);
        t_out_item   res;
        logic [14:0] key;
        int          first;
        int          best_d;
        int          best_s;
        int          slot;
        int          d;
        bit          hit;
        res = '0;
        hit = 1'b0;
        key = {to_five(px.blue_in), to_five(px.green_in), to_five(px.red_in)};
        first = (pcnt_q > 5'd16) ? 16 : int'(pcnt_q);

        // Preset slots outrank the transparent color; the highest matching slot wins.
        if (first > 0) begin
            for (int s = 1; s < first; s++) begin
                if (preset_color(s) == key) begin
                    res.palette_index = 4'(s);
                    hit = 1'b1;
                end
            end
            if (!hit && key == transp_q) begin
                res.palette_index = '0;
                hit = 1'b1;
            end
        end

        // A color seen before keeps its index.
        if (!hit && map_vld[key]) begin
            res.palette_index = map_slot[key];
            hit = 1'b1;
        end

        // An unseen color is merged, added or forced onto the nearest entry.
        if (!hit) begin
            best_d = 255;
            best_s = 0;
            for (int k = 0; k < n_added && first + k < 16; k++) begin
                d = key_distance(key, pal_q[first + k]);
                if (d < best_d) begin
                    best_d = d;
                    best_s = first + k;
                end
            end
            if (best_d < int'(thr_q) && (first + n_added) != 0) begin
                res.palette_index = 4'(best_s);
                res.merged_close  = 1'b1;
            end else if (first + n_added >= 16) begin
                res.palette_index    = 4'(best_s);
                res.palette_overflow = 1'b1;
            end else begin
                slot = first + n_added;
                pal_q[slot] = key;
                n_added = (n_added + 1) % 32;
                res.palette_index = 4'(slot);
                res.entry_added   = 1'b1;
                res.added_color   = key;
            end
            map_vld[key]  = 1'b1;
            map_slot[key] = res.palette_index;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [14:0] want_v,
                                   input logic [14:0] got_v);
        if (o_fail_count < 100)
            $display("checker: result %0d: %s expected 0x%0h, got 0x%0h",
                     o_checked, what, want_v, got_v);
        o_fail_count++;
    endtask

    // All sampling happens at the rising edge; inputs only move at the falling edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_q    = THRESHOLD_RST;
            pcnt_q   = PCNT_RST;
            transp_q = '0;
            for (int r = 0; r < 4; r++) preset_q[r] = '0;
            for (int m = 0; m < 32768; m++) map_vld[m] = 1'b0;
            n_added = 0;
            index_q.delete();
        end else begin
            // Register writes.
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_THRESHOLD:   thr_q       = i_cfg_data[9:0];
                    CFG_PRESET_CNT:  pcnt_q      = i_cfg_data[4:0];
                    CFG_TRANSPARENT: transp_q    = i_cfg_data[14:0];
                    CFG_PRESET_A:    preset_q[0] = i_cfg_data;
                    CFG_PRESET_B:    preset_q[1] = i_cfg_data;
                    CFG_PRESET_C:    preset_q[2] = i_cfg_data;
                    CFG_PRESET_D:    preset_q[3] = i_cfg_data;
                    default: ;
                endcase
            end

            // A result leaving the block is matched against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (index_q.size() == 0) begin
                    report_mismatch("item with nothing outstanding, index",
                                    '0, 15'(i_out_item.palette_index));
                end else begin
                    want = index_q.pop_front();
                    if (i_out_item.palette_index !== want.palette_index)
                        report_mismatch("palette_index", 15'(want.palette_index),
                                        15'(i_out_item.palette_index));
                    if (i_out_item.entry_added !== want.entry_added)
                        report_mismatch("entry_added", 15'(want.entry_added),
                                        15'(i_out_item.entry_added));
                    if (i_out_item.added_color !== want.added_color)
                        report_mismatch("added_color", want.added_color,
                                        i_out_item.added_color);
                    if (i_out_item.merged_close !== want.merged_close)
                        report_mismatch("merged_close", 15'(want.merged_close),
                                        15'(i_out_item.merged_close));
                    if (i_out_item.palette_overflow !== want.palette_overflow)
                        report_mismatch("palette_overflow", 15'(want.palette_overflow),
                                        15'(i_out_item.palette_overflow));
                end
                o_checked++;
            end

            // A pixel entering the block gets its prediction.
            if (i_in_valid && !i_in_stall) begin
                want = quantize_pixel(i_in_item);
                if (want.entry_added)      o_adds++;
                if (want.merged_close)     o_merges++;
                if (want.palette_overflow) o_overflows++;
                index_q.push_back(want);
            end
        end
        o_pending     = index_q.size();
        o_added_count = n_added;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the palette quantizer testbench: clock, reset, register settings and pixel
// stimulus with random idling on both sides. Depends on apq_pkg, the core and
// apq_checker, which predicts and compares the results.
`timescale 1ns / 100ps

module testbench;
    import apq_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  pix_valid;
    logic                  pix_stall;
    t_in_item              pix_item;
    logic                  res_valid;
    logic                  res_stall;
    t_out_item             res_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int added_count;
    int adds;
    int merges;
    int overflows;

    // Stimulus-side copy of what was written, used to aim pixels at presets.
    logic [63:0] preset_mirror [4];
    logic [14:0] transp_mirror;

    // Recently sent pixels, reused for repeats and near colors.
    t_in_item hist [256];
    int       hist_n;

    bit calm;
    bit no_idle;
    bit hold_req;

    adaptive_palette_quantizer_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (pix_valid),
        .o_in_stall  (pix_stall),
        .i_in_item   (pix_item),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_item  (res_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    apq_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (pix_valid),
        .i_in_stall    (pix_stall),
        .i_in_item     (pix_item),
        .i_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .i_out_item    (res_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_added_count (added_count),
        .o_adds        (adds),
        .o_merges      (merges),
        .o_overflows   (overflows)
    );

    // 2 ns clock.
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Hard limit on the run time.
    initial begin
        #1500000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random stall bursts, calm stretches, and one long hold-off.
    initial begin : result_side
        int stall_left;
        int cyc;
        bit held;
        stall_left = 0;
        cyc = 0;
        held = 1'b0;
        res_stall = 1'b0;
        calm = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 128 == 0) calm = ($urandom_range(0, 2) == 0);
            if (hold_req && !held) begin
                held = 1'b1;
                res_stall = 1'b1;
                repeat (400) @(negedge clk);
                res_stall = 1'b0;
            end else if (no_idle || calm) begin
                stall_left = 0;
                res_stall = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_stall = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                res_stall = 1'b1;
            end else begin
                res_stall = 1'b0;
            end
        end
    end

    task automatic write_reg(input t_cfg_reg which, input logic [63:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = which;
        cfg_data = value;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (which)
            CFG_TRANSPARENT: transp_mirror    = value[14:0];
            CFG_PRESET_A:    preset_mirror[0] = value;
            CFG_PRESET_B:    preset_mirror[1] = value;
            CFG_PRESET_C:    preset_mirror[2] = value;
            CFG_PRESET_D:    preset_mirror[3] = value;
            default: ;
        endcase
    endtask

    // Offers one pixel at the falling edge and holds it until it is taken.
    task automatic send_pixel(input t_in_item px);
        int gap;
        pix_item  = px;
        pix_valid = 1'b1;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        @(negedge clk);
        hist[hist_n % 256] = px;
        hist_n++;
        gap = 0;
        if (!no_idle && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
        if (gap > 0) begin
            pix_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Waits until every pixel sent so far has its result back.
    task automatic drain();
        pix_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // A pixel whose channels reduce exactly to the given RGB555 color.
    function automatic t_in_item pixel_of(input logic [14:0] key);
        t_in_item px;
        px.red_in   = {key[4:0],   3'($urandom)};
        px.green_in = {key[9:5],   3'($urandom)};
        px.blue_in  = {key[14:10], 3'($urandom)};
        return px;
    endfunction

    function automatic t_in_item pick_pixel();
        t_in_item   px;
        int         kind;
        int         lim;
        int         slot;
        logic [7:0] v;
        bit         up;
        kind = $urandom_range(0, 9);
        lim = (hist_n > 256) ? 256 : hist_n;
        px = {8'($urandom), 8'($urandom), 8'($urandom)};
        if (kind <= 2 && lim > 0) begin
            px = hist[$urandom_range(0, lim - 1)];
        end else if (kind <= 4 && lim > 0) begin
            // A variant of a recent color: one channel takes a random channel's value moved by about one step.
            px = hist[$urandom_range(0, lim - 1)];
            up = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 2))
                0: v = px.red_in;
                1: v = px.green_in;
                default: v = px.blue_in;
            endcase
            if (up) v = (v > 8'd247) ? 8'd255 : v + 8'd8;
            else    v = (v < 8'd8) ? 8'd0 : v - 8'd8;
            case ($urandom_range(0, 2))
                0: px.red_in = v;
                1: px.green_in = v;
                default: px.blue_in = v;
            endcase
        end else if (kind == 5) begin
            slot = $urandom_range(0, 15);
            if (slot == 0) px = pixel_of(transp_mirror);
            else px = pixel_of(preset_mirror[slot / 4][16 * (slot % 4) +: 15]);
        end
        return px;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) send_pixel(pick_pixel());
    endtask

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        logic [14:0] far_key;
        rst_n     = 1'b0;
        pix_valid = 1'b0;
        pix_item  = '0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        hist_n    = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        transp_mirror = '0;
        for (int r = 0; r < 4; r++) preset_mirror[r] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // The color map is cleared after reset; the input stays stalled meanwhile.
        @(negedge clk);
        while (pix_stall) @(negedge clk);

        // Every slot reserved, so nothing is ever added here.
        write_reg(CFG_PRESET_CNT, 64'd0);
        write_reg(CFG_THRESHOLD, 64'd10);
        write_reg(CFG_PRESET_A, random64() | 64'h8000);
        write_reg(CFG_PRESET_B, random64());
        write_reg(CFG_PRESET_C, random64());
        write_reg(CFG_PRESET_D, random64());
        // Slot 9 repeats the color of slot 2, so the higher slot must win.
        write_reg(CFG_PRESET_C, {preset_mirror[2][63:32], 1'b1,
                                 preset_mirror[0][46:32], preset_mirror[2][15:0]});
        write_reg(CFG_TRANSPARENT, 64'h0421);
        write_reg(CFG_PRESET_CNT, 64'd16);

        send_pixel('{8'd0, 8'd0, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd255, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd255});
        send_pixel('{8'd7, 8'd7, 8'd7});
        send_pixel('{8'd8, 8'd8, 8'd8});
        send_pixel('{8'd247, 8'd248, 8'd247});
        send_pixel(pixel_of(transp_mirror));
        send_pixel(pixel_of(preset_mirror[0][46:32]));
        send_pixel(pixel_of(preset_mirror[3][62:48]));
        send_pixel(pixel_of(preset_mirror[0][30:16]));
        send_pixel('{8'd255, 8'd255, 8'd255});
        run_random(150);
        drain();

        // Oversized preset count, threshold above the saturated distance, and a
        // transparent color that a preset slot shadows.
        write_reg(CFG_PRESET_CNT, 64'd31);
        write_reg(CFG_THRESHOLD, 64'd1023);
        write_reg(CFG_TRANSPARENT, {49'd0, preset_mirror[0][62:48]});
        send_pixel('{8'd100, 8'd30, 8'd200});
        send_pixel(pixel_of(preset_mirror[3][62:48]));
        send_pixel(pixel_of(transp_mirror));
        run_random(100);
        drain();

        // Five reserved slots; adaptive entries fill slots 5 to 15.
        write_reg(CFG_PRESET_CNT, 64'd5);
        write_reg(CFG_THRESHOLD, 64'd10);
        write_reg(CFG_TRANSPARENT, 64'h7fff);
        write_reg(CFG_PRESET_B, random64());
        far_key = {5'd24, 5'd8, 5'd16};
        send_pixel(pixel_of(far_key));
        send_pixel(pixel_of(far_key + 15'd1));
        send_pixel(pixel_of(preset_mirror[3][46:32]));
        send_pixel(pixel_of(transp_mirror));
        send_pixel(pixel_of(preset_mirror[1][14:0]));
        while (added_count < 11) send_pixel({8'($urandom), 8'($urandom), 8'($urandom)});
        run_random(100);
        // Long hold-off on the result side while pixels keep coming.
        hold_req = 1'b1;
        run_random(350);
        drain();

        // Zero threshold: a full palette forces every new color.
        write_reg(CFG_THRESHOLD, 64'd0);
        run_random(120);
        drain();
        run_random(130);
        drain();

        write_reg(CFG_PRESET_CNT, 64'd8);
        write_reg(CFG_THRESHOLD, 64'd255);
        write_reg(CFG_TRANSPARENT, 64'h7fff);
        write_reg(CFG_PRESET_A, random64());
        write_reg(CFG_PRESET_B, 64'hffff_ffff_ffff_ffff);
        run_random(300);
        drain();

        write_reg(CFG_PRESET_CNT, 64'd15);
        write_reg(CFG_THRESHOLD, 64'd256);
        write_reg(CFG_PRESET_C, random64());
        write_reg(CFG_PRESET_D, 64'd0);
        run_random(200);
        drain();

        write_reg(CFG_PRESET_CNT, 64'd16);
        write_reg(CFG_THRESHOLD, 64'd1023);
        write_reg(CFG_TRANSPARENT, 64'd0);
        write_reg(CFG_PRESET_A, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_PRESET_D, random64());
        run_random(100);
        // Full rate to the end.
        no_idle = 1'b1;
        run_random(60);
        drain();
        repeat (30) @(negedge clk);

        $display("summary: %0d pixels checked under seven register settings",
                 checked);
        $display("summary: %0d entries added, %0d merged, %0d forced onto a full palette",
                 adds, merges, overflows);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/apq_pkg.sv
src/apq_map_mem.sv
src/apq_palette.sv
src/adaptive_palette_quantizer_core.sv
tb/apq_checker.sv
tb/testbench.sv
